// ===== sv/cfla_pkg.sv =====
// Package: shared constants, payload structs, op codes and sequencer states.
`default_nettype none
package cfla_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int TOT_W = 32 + CNT_W;

    localparam logic [31:0] PAGE_MASK_LOW  = 32'h0000_0fff;
    localparam logic [31:0] PAGE_MASK_HIGH = 32'hffff_f000;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TOTAL = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_LOST  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_RM,
        S_INS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_entry;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] region_addr;
        logic [31:0] region_size;
    } t_cmd;

    typedef struct packed {
        logic [31:0]      alloc_addr;
        logic [1:0]       status;
        logic [32:0]      total_free;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] peak_entries;
        logic [31:0]      lost_count;
        logic [31:0]      lost_bytes;
    } t_res;
endpackage
`default_nettype wire

// ===== sv/cfla_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module cfla_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/coalescing_free_list_allocator_core.sv =====
// Top level: first-fit free-list allocator with coalescing, table in one RAM.
//
// Commands: drive i_cmd and raise i_start; the word is taken at an edge where
// o_busy is low. Each command yields one result word on o_res for exactly
// one cycle, marked by o_res_valid; the receiver must take it then.
// Configuration: i_cfg_valid/o_cfg_ready write the page rounding bit; ready
// is high only while the block is idle.
// Timing: the table sits in one RAM with one read and one write per cycle.
// Allocate scans one entry per cycle up to the first fit, then removes an
// emptied entry by moving the tail down one entry per cycle. Free scans to
// its sorted slot, then may move the tail down (double merge) or up (insert)
// one entry per cycle. Scan and shift together cover the table once. For total
// and clear the result word comes in the cycle after the accepting edge, and
// the next command is taken only once the block is back in idle after the
// result word. Commands are handled one at a time.
// Reset empties the table (count zero, no clearing pass), zeroes statistics
// and rounding. The total free size is kept as a running sum.
`default_nettype none
module coalescing_free_list_allocator_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    output logic              o_busy,
    input  wire  cfla_pkg::t_cmd i_cmd,
    output logic              o_res_valid,
    output cfla_pkg::t_res    o_res,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire               i_cfg_data
);
    import cfla_pkg::*;

    t_state           r_state, n_state;
    logic [1:0]       r_op, n_op;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_size, n_size;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_k, n_k;
    t_entry           r_prev, n_prev;
    t_entry           r_ins, n_ins;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_peak, n_peak;
    logic [31:0]      r_dcnt, n_dcnt;
    logic [31:0]      r_dbytes, n_dbytes;
    logic [TOT_W-1:0] r_total, n_total;
    logic [31:0]      r_res_addr, n_res_addr;
    logic [1:0]       r_status, n_status;
    logic             r_round;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_entry           wdata, rdata;

    logic [CNT_W-1:0] i_plus1, i_minus1, k_plus2, k_minus2, n_minus1;
    logic [31:0]      rnd_size, prev_end, free_end, len_left;
    logic [31:0]      merged_prev, merged_both, merged_next;
    logic [32:0]      dbytes_sum;
    logic             in_range, prev_merge, next_merge;

    cfla_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH($bits(t_entry))) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign i_plus1     = r_i + CNT_W'(1);
    assign i_minus1    = r_i - CNT_W'(1);
    assign k_plus2     = r_k + CNT_W'(2);
    assign k_minus2    = r_k - CNT_W'(2);
    assign n_minus1    = r_n - CNT_W'(1);
    assign rnd_size    = r_round ? ((i_cmd.region_size + PAGE_MASK_LOW) & PAGE_MASK_HIGH)
                                 : i_cmd.region_size;
    assign in_range    = r_i < r_n;
    assign prev_end    = r_prev.start + r_prev.len;
    assign free_end    = r_addr + r_size;
    assign len_left    = rdata.len - r_size;
    assign merged_prev = r_prev.len + r_size;
    assign merged_both = merged_prev + rdata.len;
    assign merged_next = rdata.len + r_size;
    assign prev_merge  = (r_i != '0) && (prev_end == r_addr);
    assign next_merge  = in_range && (free_end == rdata.start);
    assign dbytes_sum  = {1'b0, r_dbytes} + {1'b0, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_peak   <= '0;
            r_dcnt   <= '0;
            r_dbytes <= '0;
            r_total  <= '0;
            r_round  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_peak   <= n_peak;
            r_dcnt   <= n_dcnt;
            r_dbytes <= n_dbytes;
            r_total  <= n_total;
            if (i_cfg_valid && o_cfg_ready) begin
                r_round <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_addr     <= n_addr;
        r_size     <= n_size;
        r_i        <= n_i;
        r_k        <= n_k;
        r_prev     <= n_prev;
        r_ins      <= n_ins;
        r_res_addr <= n_res_addr;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_addr     = r_addr;
        n_size     = r_size;
        n_i        = r_i;
        n_k        = r_k;
        n_prev     = r_prev;
        n_ins      = r_ins;
        n_n        = r_n;
        n_peak     = r_peak;
        n_dcnt     = r_dcnt;
        n_dbytes   = r_dbytes;
        n_total    = r_total;
        n_res_addr = r_res_addr;
        n_status   = r_status;
        we         = 1'b0;
        waddr      = r_i[IDX_W-1:0];
        wdata      = rdata;
        raddr      = i_plus1[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (i_start) begin
                    n_op       = i_cmd.op;
                    n_addr     = i_cmd.region_addr;
                    n_size     = rnd_size;
                    n_i        = '0;
                    n_res_addr = '0;
                    n_status   = ST_OK;
                    case (t_op'(i_cmd.op))
                        OP_ALLOC, OP_FREE: n_state = S_SRCH;
                        OP_CLEAR: begin
                            n_n      = '0;
                            n_peak   = '0;
                            n_dcnt   = '0;
                            n_dbytes = '0;
                            n_total  = '0;
                            n_state  = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SRCH: begin
                if (t_op'(r_op) == OP_ALLOC) begin
                    if (!in_range) begin
                        n_status = ST_NOFIT;
                        n_state  = S_DONE;
                    end else if (rdata.len >= r_size) begin
                        n_res_addr = rdata.start;
                        n_total    = r_total - TOT_W'(r_size);
                        if (len_left != '0) begin
                            we          = 1'b1;
                            wdata.start = rdata.start + r_size;
                            wdata.len   = len_left;
                            n_state     = S_DONE;
                        end else begin
                            n_n     = n_minus1;
                            n_k     = r_i;
                            n_state = S_RM;
                        end
                    end else begin
                        n_i = i_plus1;
                    end
                end else begin
                    if (in_range && !(rdata.start > r_addr)) begin
                        n_prev = rdata;
                        n_i    = i_plus1;
                    end else if (prev_merge) begin
                        we          = 1'b1;
                        waddr       = i_minus1[IDX_W-1:0];
                        wdata.start = r_prev.start;
                        if (next_merge) begin
                            wdata.len = merged_both;
                            n_total   = r_total + TOT_W'(merged_both)
                                        - TOT_W'(r_prev.len) - TOT_W'(rdata.len);
                            n_n       = n_minus1;
                            n_k       = r_i;
                            n_state   = S_RM;
                        end else begin
                            wdata.len = merged_prev;
                            n_total   = r_total + TOT_W'(merged_prev) - TOT_W'(r_prev.len);
                            n_state   = S_DONE;
                        end
                    end else if (next_merge) begin
                        we          = 1'b1;
                        wdata.start = r_addr;
                        wdata.len   = merged_next;
                        n_total     = r_total + TOT_W'(merged_next) - TOT_W'(rdata.len);
                        n_state     = S_DONE;
                    end else if (r_n < CNT_W'(TABLE_ENTRIES)) begin
                        raddr     = n_minus1[IDX_W-1:0];
                        n_k       = r_n;
                        n_n       = r_n + CNT_W'(1);
                        if (r_peak < n_n) begin
                            n_peak = n_n;
                        end
                        n_ins.start = r_addr;
                        n_ins.len   = r_size;
                        n_total     = r_total + TOT_W'(r_size);
                        n_state     = S_INS;
                    end else begin
                        n_status = ST_LOST;
                        if (r_dcnt != '1) begin
                            n_dcnt = r_dcnt + 32'd1;
                        end
                        n_dbytes = dbytes_sum[32] ? '1 : dbytes_sum[31:0];
                        n_state  = S_DONE;
                    end
                end
            end
            S_RM: begin
                raddr = k_plus2[IDX_W-1:0];
                if (r_k < r_n) begin
                    we    = 1'b1;
                    waddr = r_k[IDX_W-1:0];
                    n_k   = r_k + CNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                raddr = k_minus2[IDX_W-1:0];
                we    = 1'b1;
                if (r_k > r_i) begin
                    waddr = r_k[IDX_W-1:0];
                    n_k   = r_k - CNT_W'(1);
                end else begin
                    waddr   = r_i[IDX_W-1:0];
                    wdata   = r_ins;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.alloc_addr   = r_res_addr;
        o_res.status       = r_status;
        o_res.entry_count  = r_n;
        o_res.peak_entries = r_peak;
        o_res.lost_count   = r_dcnt;
        o_res.lost_bytes   = r_dbytes;
        if ((|r_total[TOT_W-1:33]) || (r_total[32] && (|r_total[31:0]))) begin
            o_res.total_free = {1'b1, 32'd0};
        end else begin
            o_res.total_free = r_total[32:0];
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench: drives allocator commands and checks each result against a behavioral predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfla_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int TAIL = 2 * TABLE_ENTRIES + 20;

    logic i_clk, i_rst_n, i_start, o_busy, o_res_valid;
    logic i_cfg_valid, o_cfg_ready, i_cfg_data;
    t_cmd i_cmd;
    t_res o_res;

    coalescing_free_list_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .o_res_valid(o_res_valid), .o_res(o_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [31:0] fl_start [TABLE_ENTRIES];
    logic [31:0] fl_len [TABLE_ENTRIES];
    int unsigned fl_count, fl_peak;
    logic [31:0] fl_lost_n, fl_lost_b;
    logic fl_round;

    t_cmd cmd_q[$];
    t_res result_q[$];
    int errors = 0;
    int idle_cycles = 0;
    int gap = 0;
    logic cfg_pending = 0;
    logic cfg_value = 0;
    logic [31:0] last_free_end = 32'h1000;

    function automatic void drop_at(int unsigned pos);
        fl_count--;
        for (int unsigned k = pos; k < fl_count; k++) begin
            fl_start[k] = fl_start[k + 1];
            fl_len[k] = fl_len[k + 1];
        end
    endfunction

    function automatic t_res predict_cmd(t_cmd c);
        t_res r;
        logic [31:0] sz;
        logic [63:0] tot;
        int unsigned i;
        bit done;
        r = '0;
        sz = c.region_size;
        if (fl_round) sz = (sz + PAGE_MASK_LOW) & PAGE_MASK_HIGH;
        r.status = ST_OK;
        case (t_op'(c.op))
            OP_ALLOC: begin
                done = 0;
                r.status = ST_NOFIT;
                for (i = 0; i < fl_count && !done; i++) begin
                    if (fl_len[i] >= sz) begin
                        r.alloc_addr = fl_start[i];
                        r.status = ST_OK;
                        fl_start[i] += sz;
                        fl_len[i] -= sz;
                        if (fl_len[i] == 0) drop_at(i);
                        done = 1;
                    end
                end
            end
            OP_FREE: begin
                for (i = 0; i < fl_count; i++) if (fl_start[i] > c.region_addr) break;
                if (i > 0 && 32'(fl_start[i-1] + fl_len[i-1]) == c.region_addr) begin
                    fl_len[i-1] += sz;
                    if (i < fl_count && 32'(c.region_addr + sz) == fl_start[i]) begin
                        fl_len[i-1] += fl_len[i];
                        drop_at(i);
                    end
                end else if (i < fl_count && 32'(c.region_addr + sz) == fl_start[i]) begin
                    fl_start[i] = c.region_addr;
                    fl_len[i] += sz;
                end else if (fl_count < TABLE_ENTRIES) begin
                    for (int unsigned k = fl_count; k > i; k--) begin
                        fl_start[k] = fl_start[k-1];
                        fl_len[k] = fl_len[k-1];
                    end
                    fl_count++;
                    if (fl_peak < fl_count) fl_peak = fl_count;
                    fl_start[i] = c.region_addr;
                    fl_len[i] = sz;
                end else begin
                    r.status = ST_LOST;
                    if (fl_lost_n != 32'hffffffff) fl_lost_n++;
                    if (sz > 32'hffffffff - fl_lost_b) fl_lost_b = 32'hffffffff;
                    else fl_lost_b += sz;
                end
            end
            OP_CLEAR: begin
                fl_count = 0; fl_peak = 0; fl_lost_n = 0; fl_lost_b = 0;
            end
            default: ;
        endcase
        tot = 0;
        for (i = 0; i < fl_count; i++) tot += fl_len[i];
        if (tot > 64'h1_0000_0000) tot = 64'h1_0000_0000;
        r.total_free = tot[32:0];
        r.entry_count = fl_count[CNT_W-1:0];
        r.peak_entries = fl_peak[CNT_W-1:0];
        r.lost_count = fl_lost_n;
        r.lost_bytes = fl_lost_b;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 0;
            i_cfg_valid <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                i_cfg_valid <= 0;
                fl_round = i_cfg_data;
                cfg_pending = 0;
            end else if (cfg_pending && !i_cfg_valid) begin
                i_cfg_valid <= 1;
                i_cfg_data <= cfg_value;
            end
            if (i_start && !o_busy) begin
                result_q.push_back(predict_cmd(i_cmd));
                gap = pick_gap();
            end
            if ((i_start && !o_busy) || !i_start) begin
                if (gap > 0 || cmd_q.size() == 0 || cfg_pending) begin
                    if (gap > 0) gap--;
                    i_start <= 0;
                end else begin
                    i_cmd <= cmd_q.pop_front();
                    i_start <= 1;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (result_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                t_res e;
                e = result_q.pop_front();
                if (o_res.alloc_addr !== e.alloc_addr) begin
                    $error("alloc_addr exp %h got %h", e.alloc_addr, o_res.alloc_addr); errors++;
                end
                if (o_res.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_res.status); errors++;
                end
                if (o_res.total_free !== e.total_free) begin
                    $error("total_free exp %h got %h", e.total_free, o_res.total_free); errors++;
                end
                if (o_res.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count, o_res.entry_count);
                    errors++;
                end
                if (o_res.peak_entries !== e.peak_entries) begin
                    $error("peak_entries exp %0d got %0d", e.peak_entries, o_res.peak_entries);
                    errors++;
                end
                if (o_res.lost_count !== e.lost_count) begin
                    $error("lost_count exp %h got %h", e.lost_count, o_res.lost_count); errors++;
                end
                if (o_res.lost_bytes !== e.lost_bytes) begin
                    $error("lost_bytes exp %h got %h", e.lost_bytes, o_res.lost_bytes); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_cmd(t_op op, logic [31:0] a, logic [31:0] s);
        t_cmd c;
        c.op = op;
        c.region_addr = a;
        c.region_size = s;
        cmd_q.push_back(c);
    endtask

    task automatic drain();
        wait (cmd_q.size() == 0 && !i_start && result_q.size() == 0);
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic set_rounding(logic v);
        drain();
        @(posedge i_clk);
        cfg_value = v;
        cfg_pending = 1;
        wait (!cfg_pending);
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int r;
        logic [31:0] a, s;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                s = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 12000);
                if ($urandom_range(0, 2) == 0) a = last_free_end;
                else a = $urandom_range(0, 1) ? $urandom : (32'($urandom_range(0, 255)) << 12);
                push_cmd(OP_FREE, a, s);
                last_free_end = a + s + (($urandom_range(0, 1)) ? 0 : 32'h100);
            end else if (r < 85) begin
                s = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 9000);
                push_cmd(OP_ALLOC, $urandom, s);
            end else if (r < 97) begin
                push_cmd(OP_TOTAL, $urandom, $urandom);
            end else begin
                push_cmd(OP_CLEAR, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_start = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        i_cmd = '0;
        fl_count = 0; fl_peak = 0; fl_lost_n = 0; fl_lost_b = 0; fl_round = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        // directed
        push_cmd(OP_ALLOC, 32'h0, 32'h0);
        push_cmd(OP_TOTAL, 32'hffffffff, 32'hffffffff);
        push_cmd(OP_FREE, 32'h0, 32'h100);
        push_cmd(OP_ALLOC, 32'hffffffff, 32'h0);
        push_cmd(OP_ALLOC, 32'h0, 32'h10);
        push_cmd(OP_FREE, 32'h200, 32'h100);
        push_cmd(OP_FREE, 32'h100, 32'h100);
        push_cmd(OP_FREE, 32'h0, 32'h10);
        push_cmd(OP_FREE, 32'hffff_fff0, 32'h10);
        push_cmd(OP_FREE, 32'h8000_0000, 32'hffffffff);
        push_cmd(OP_FREE, 32'h4000_0000, 32'hc000_0000);
        push_cmd(OP_TOTAL, 0, 0);
        push_cmd(OP_ALLOC, 0, 32'hffffffff);
        push_cmd(OP_ALLOC, 0, 32'h1000);
        push_cmd(OP_CLEAR, 32'hffffffff, 32'hffffffff);
        push_cmd(OP_ALLOC, 0, 32'h5);
        set_rounding(1);
        push_cmd(OP_FREE, 32'h5000, 32'h1);
        push_cmd(OP_FREE, 32'h1000, 32'hffff_f001);
        push_cmd(OP_ALLOC, 0, 32'hffff_ffff);
        push_cmd(OP_ALLOC, 0, 32'h1001);
        push_cmd(OP_TOTAL, 0, 0);
        random_phase(60);
        set_rounding(0);
        random_phase(80);
        drain();
        push_cmd(OP_CLEAR, 0, 0);
        set_rounding(1);
        random_phase(70);
        set_rounding(0);
        random_phase(60);
        drain();
        if (errors == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
